/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the CV store design.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define CVS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cv store assertion failed");

// Next-cycle implication, disabled while in reset
`define CVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cv store assertion failed");

`endif

/* design/cvs_pkg.sv */
// ---------------------------------------------------------------------------
// cvs_pkg
// Shared types and constants of the CV store: request codes, register map,
// decoded request and execute result structs.
// ---------------------------------------------------------------------------
package cvs_pkg;

   // Default CV memory depth
   localparam int CV_COUNT_DEF = 256;

   // Action codes
   localparam logic [1:0] ACT_GET    = 2'd0;
   localparam logic [1:0] ACT_SET    = 2'd1;
   localparam logic [1:0] ACT_VERIFY = 2'd2;

   // Address kinds
   localparam logic [1:0] KIND_REG  = 2'd0;
   localparam logic [1:0] KIND_PAGE = 2'd1;
   localparam logic [1:0] KIND_CV   = 2'd2;
   localparam logic [1:0] KIND_BIT  = 2'd3;

   // Register map
   localparam logic [9:0] REG_FIRST    = 10'd1;
   localparam logic [9:0] REG_LOW_LAST = 10'd4;
   localparam logic [9:0] REG_CFG      = 10'd5;
   localparam logic [9:0] REG_PAGE     = 10'd6;
   localparam logic [9:0] REG_LAST     = 10'd8;
   localparam logic [9:0] REG5_CV      = 10'd29;

   // Bit access limits and page reset value
   localparam logic [3:0] BIT_COUNT  = 4'd8;
   localparam logic [7:0] PAGE_RESET = 8'd1;

   // Decoded request held in the input stage
   typedef struct packed {
      logic [1:0] action;
      logic [1:0] kind;
      logic       act_ok;
      logic       addr_ok;
      logic       is_page;
      logic       reg_low;
      logic [2:0] bit_sel;
      logic [7:0] value;
   } dec_type;

   // Execute result: state updates and response
   typedef struct packed {
      logic       mem_we;
      logic [7:0] mem_wdata;
      logic       page_we;
      logic [7:0] page_wdata;
      logic [7:0] value_out;
      logic       failed;
   } exec_type;

endpackage

/* design/cvs_decode.sv */
// ---------------------------------------------------------------------------
// cvs_decode
// Decodes one request: range checks, register map and memory address.
// ---------------------------------------------------------------------------
module cvs_decode
   import cvs_pkg::*;
#(
   parameter int CV_COUNT = CV_COUNT_DEF,
   localparam int AW = $clog2(CV_COUNT)
) (
   input  logic [1:0]    action,
   input  logic [1:0]    addr_kind,
   input  logic [9:0]    location,
   input  logic [3:0]    bit_index,
   input  logic [7:0]    value_in,
   output dec_type       dec,
   output logic [AW-1:0] addr
);

   logic cv_ok;
   logic reg_ok;

   // Range checks
   assign cv_ok  = ({1'b0, location} < 11'(CV_COUNT));
   assign reg_ok = (location >= REG_FIRST) && (location <= REG_LAST);

   always_comb begin
      dec.action  = action;
      dec.kind    = addr_kind;
      dec.act_ok  = (action == ACT_GET) || (action == ACT_SET) || (action == ACT_VERIFY);
      dec.is_page = (addr_kind == KIND_REG) && (location == REG_PAGE);
      dec.reg_low = (addr_kind == KIND_REG) && reg_ok && (location <= REG_LOW_LAST);
      dec.bit_sel = bit_index[2:0];
      dec.value   = value_in;
      addr        = '0;
      unique case (addr_kind)
         KIND_REG: begin
            dec.addr_ok = reg_ok;
            if (reg_ok) begin
               addr = (location == REG_CFG) ? AW'(REG5_CV) : AW'(location);
            end
         end
         KIND_BIT: begin
            dec.addr_ok = cv_ok && (bit_index < BIT_COUNT);
            if (cv_ok) begin
               addr = AW'(location);
            end
         end
         default: begin
            dec.addr_ok = cv_ok;
            if (cv_ok) begin
               addr = AW'(location);
            end
         end
      endcase
   end

endmodule

/* design/cvs_exec.sv */
// ---------------------------------------------------------------------------
// cvs_exec
// Executes one decoded request against the read CV byte and page register.
// ---------------------------------------------------------------------------
module cvs_exec
   import cvs_pkg::*;
(
   input  dec_type    dec,
   input  logic [7:0] rd_data,
   input  logic [7:0] page_value,
   output exec_type   res
);

   logic [7:0] stored;
   logic       cur;
   logic [7:0] bit_byte;
   logic       ok;
   logic [7:0] val;

   always_comb begin
      stored   = dec.is_page ? page_value : rd_data;
      cur      = rd_data[dec.bit_sel];
      bit_byte = rd_data;
      bit_byte[dec.bit_sel] = dec.value[0];
      ok       = 1'b0;
      val      = '0;
      res.mem_we     = 1'b0;
      res.mem_wdata  = dec.value;
      res.page_we    = 1'b0;
      res.page_wdata = dec.value;

      if (dec.act_ok && dec.addr_ok) begin
         // Any access to registers 1-4 resets the page register
         if (dec.reg_low) begin
            res.page_we    = 1'b1;
            res.page_wdata = PAGE_RESET;
         end
         if (dec.kind != KIND_BIT) begin
            // Byte access: register, page or CV
            unique case (dec.action)
               ACT_GET: begin
                  ok  = 1'b1;
                  val = stored;
               end
               ACT_SET: begin
                  ok  = 1'b1;
                  val = dec.value;
                  if (dec.is_page) begin
                     res.page_we    = 1'b1;
                     res.page_wdata = dec.value;
                  end else begin
                     res.mem_we = 1'b1;
                  end
               end
               default: begin
                  ok  = (stored == dec.value);
                  val = dec.value;
               end
            endcase
         end else begin
            // Single bit access
            unique case (dec.action)
               ACT_GET: begin
                  ok  = 1'b1;
                  val = {7'd0, cur};
               end
               ACT_SET: begin
                  if (dec.value[7:1] == 7'd0) begin
                     ok            = 1'b1;
                     val           = dec.value;
                     res.mem_we    = 1'b1;
                     res.mem_wdata = bit_byte;
                  end
               end
               default: begin
                  ok  = (dec.value == {7'd0, cur});
                  val = dec.value;
               end
            endcase
         end
      end

      res.value_out = ok ? val : 8'd0;
      res.failed    = !ok;
   end

endmodule

/* design/cvs_mem.sv */
// ---------------------------------------------------------------------------
// cvs_mem
// CV byte memory: one write port, one registered read port with bypass of
// the write in the same cycle.
// ---------------------------------------------------------------------------
module cvs_mem
   import cvs_pkg::*;
#(
   parameter int CV_COUNT = CV_COUNT_DEF,
   localparam int AW = $clog2(CV_COUNT)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [CV_COUNT];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; take the write data when both hit the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/decoder_cv_store_core.sv */
// Service-mode CV store: accepts one get, set or verify request per clock
// and presents one result per clock while the result side keeps up; each
// result passes through the request stage and then the result register.
// The rate is set by the single CV memory read-modify-write per request:
// the byte is read at the request transfer and written back as the request
// leaves the request stage, with a bypass so that back-to-back requests to
// the same CV see each other's writes. After reset a clearing pass zeroes
// the CV memory, one entry a cycle; req_ready stays low until it is done.
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// decoder_cv_store_core
// Top level: request stage, CV memory, page register and result register.
// ---------------------------------------------------------------------------
module decoder_cv_store_core
   import cvs_pkg::*;
#(
   parameter int CV_COUNT = CV_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [1:0] req_addr_kind,
   input  logic [9:0] req_location,
   input  logic [3:0] req_bit_index,
   input  logic [7:0] req_value_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_value_out,
   output logic       rsp_failed
);

   localparam int AW = $clog2(CV_COUNT);

   dec_type       dec;
   logic [AW-1:0] dec_addr;
   dec_type       s1_dec_ff;
   logic [AW-1:0] s1_addr_ff;
   logic          s1_valid_ff;
   logic          s1_advance;
   logic          req_xfer;
   exec_type      exe;
   logic [7:0]    rd_data;
   logic [7:0]    page_ff;
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_value_out_ff;
   logic          rsp_failed_ff;

   // Handshake
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !clr_busy_ff && (!s1_valid_ff || s1_advance);
   assign req_xfer   = req_valid && req_ready;

   cvs_decode #(.CV_COUNT(CV_COUNT)) u_decode (
      .action    (req_action),
      .addr_kind (req_addr_kind),
      .location  (req_location),
      .bit_index (req_bit_index),
      .value_in  (req_value_in),
      .dec       (dec),
      .addr      (dec_addr)
   );

   // Memory write port: clearing pass, else the executing request
   assign mem_we    = clr_busy_ff || (s1_advance && exe.mem_we);
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : s1_addr_ff;
   assign mem_wdata = clr_busy_ff ? 8'd0 : exe.mem_wdata;

   cvs_mem #(.CV_COUNT(CV_COUNT)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (req_xfer),
      .rd_addr (dec_addr),
      .rd_data (rd_data)
   );

   cvs_exec u_exec (
      .dec        (s1_dec_ff),
      .rd_data    (rd_data),
      .page_value (page_ff),
      .res        (exe)
   );

   // Clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(CV_COUNT - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Request stage: hold the decoded request while the read completes
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_dec_ff  <= dec;
         s1_addr_ff <= dec_addr;
      end
   end

   // Page register
   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= PAGE_RESET;
      end else if (s1_advance && exe.page_we) begin
         page_ff <= exe.page_wdata;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_value_out_ff <= exe.value_out;
         rsp_failed_ff    <= exe.failed;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_out_ff;
   assign rsp_failed    = rsp_failed_ff;

   // Checks
   `CVS_ASSERT_NOW(a_no_req_in_clear, clock, reset, clr_busy_ff, !req_ready && !s1_valid_ff)
   `CVS_ASSERT_NOW(a_page_reset_in_clear, clock, reset, clr_busy_ff, page_ff == PAGE_RESET)
   `CVS_ASSERT_NEXT(a_stall_keeps_item, clock, reset, s1_valid_ff && !s1_advance, s1_valid_ff)
   `CVS_ASSERT_NOW(a_fail_zero_value, clock, reset, rsp_valid_ff && rsp_failed_ff, rsp_value_out_ff == 8'd0)
   `CVS_ASSERT_NOW(a_no_write_on_fail, clock, reset, s1_advance && exe.failed, !exe.mem_we)

endmodule

/* tb/cv_store_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cv_store_checker
// Watches the request and response channels of the CV store, keeps its own
// copy of CV memory and page register, predicts each response from the
// request transfer and compares it field by field, in order.
// ---------------------------------------------------------------------------
module cv_store_checker
   import cvs_pkg::*;
#(
   parameter int CV_COUNT = CV_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [1:0] req_addr_kind,
   input  logic [9:0] req_location,
   input  logic [3:0] req_bit_index,
   input  logic [7:0] req_value_in,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_value_out,
   input  logic       rsp_failed,
   output int         fail_count,
   output int         pending
);

   localparam int AW = $clog2(CV_COUNT);

   typedef struct packed {
      logic [7:0] value_out;
      logic       failed;
   } cv_reply_type;

   // Shadow state of the store
   logic [7:0] shadow_cv [0:CV_COUNT-1];
   logic [7:0] shadow_page;

   // Replies predicted but not yet seen, oldest first
   cv_reply_type expected_replies [$];

   // Apply one request to the shadow state and work out its reply
   task automatic apply_request(input  logic [1:0]   act,
                                input  logic [1:0]   kind,
                                input  logic [9:0]   loc,
                                input  logic [3:0]   bidx,
                                input  logic [7:0]   val,
                                output cv_reply_type reply);
      logic       ok;
      logic [7:0] res;
      logic [7:0] stored;
      logic [9:0] cv_num;
      logic       is_page;
      logic       cur;
      ok  = 1'b0;
      res = 8'd0;
      if (act == ACT_GET || act == ACT_SET || act == ACT_VERIFY) begin
         case (kind)
            KIND_REG: begin
               if (loc >= REG_FIRST && loc <= REG_LAST) begin
                  is_page = (loc == REG_PAGE);
                  cv_num  = (loc == REG_CFG) ? REG5_CV : loc;
                  // low registers pull the page back to its reset value
                  if (loc <= REG_LOW_LAST)
                     shadow_page = PAGE_RESET;
                  stored = is_page ? shadow_page : shadow_cv[AW'(cv_num)];
                  if (act == ACT_GET) begin
                     ok  = 1'b1;
                     res = stored;
                  end else if (act == ACT_SET) begin
                     if (is_page)
                        shadow_page = val;
                     else
                        shadow_cv[AW'(cv_num)] = val;
                     ok  = 1'b1;
                     res = val;
                  end else begin
                     ok  = (stored == val);
                     res = val;
                  end
               end
            end
            KIND_PAGE, KIND_CV: begin
               if (loc < CV_COUNT) begin
                  stored = shadow_cv[AW'(loc)];
                  if (act == ACT_GET) begin
                     ok  = 1'b1;
                     res = stored;
                  end else if (act == ACT_SET) begin
                     shadow_cv[AW'(loc)] = val;
                     ok  = 1'b1;
                     res = val;
                  end else begin
                     ok  = (stored == val);
                     res = val;
                  end
               end
            end
            default: begin
               if (loc < CV_COUNT && bidx < BIT_COUNT) begin
                  cur = shadow_cv[AW'(loc)][bidx[2:0]];
                  if (act == ACT_GET) begin
                     ok  = 1'b1;
                     res = {7'd0, cur};
                  end else if (act == ACT_SET) begin
                     // only 0 and 1 are legal bit values
                     if (val <= 8'd1) begin
                        shadow_cv[AW'(loc)][bidx[2:0]] = val[0];
                        ok  = 1'b1;
                        res = val;
                     end
                  end else begin
                     ok  = ({7'd0, cur} == val);
                     res = val;
                  end
               end
            end
         endcase
      end
      reply.value_out = ok ? res : 8'd0;
      reply.failed    = ~ok;
   endtask

   // Track transfers on both channels
   always @(posedge clock) begin
      cv_reply_type want;
      cv_reply_type next_reply;
      if (reset) begin
         for (int i = 0; i < CV_COUNT; i++)
            shadow_cv[AW'(i)] = 8'd0;
         shadow_page = PAGE_RESET;
         expected_replies.delete();
      end else begin
         // a response always belongs to an earlier request, so check it first
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               $error("response with nothing expected: value_out %0h failed %0b",
                      rsp_value_out, rsp_failed);
               fail_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_value_out !== want.value_out) begin
                  $error("value_out: expected %0h, actual %0h",
                         want.value_out, rsp_value_out);
                  fail_count++;
               end
               if (rsp_failed !== want.failed) begin
                  $error("failed: expected %0b, actual %0b", want.failed, rsp_failed);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_request(req_action, req_addr_kind, req_location,
                          req_bit_index, req_value_in, next_reply);
            expected_replies.push_back(next_reply);
         end
      end
      pending = expected_replies.size();
   end

endmodule

/* tb/tb_decoder_cv_store_core.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_decoder_cv_store_core
// Drives service-mode get, set and verify requests into the CV store with
// random gaps and response back-pressure; a checker beside the block
// predicts and compares every response and the verdict is given here.
// ---------------------------------------------------------------------------
module tb_decoder_cv_store_core;
   import cvs_pkg::*;

   // Action code with no meaning in the block
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 900;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_action = ACT_GET;
   logic [1:0] req_addr_kind = KIND_REG;
   logic [9:0] req_location = 10'd0;
   logic [3:0] req_bit_index = 4'd0;
   logic [7:0] req_value_in = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_value_out;
   logic       rsp_failed;
   logic       steady = 1'b0;
   int         fail_count;
   int         pending;

   decoder_cv_store_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_addr_kind (req_addr_kind),
      .req_location  (req_location),
      .req_bit_index (req_bit_index),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_failed    (rsp_failed)
   );

   cv_store_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_addr_kind (req_addr_kind),
      .req_location  (req_location),
      .req_bit_index (req_bit_index),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_failed    (rsp_failed),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the response side now and then, except in the steady stretch
   always @(posedge clock) begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 7);
   end

   // Present one request and hold it until its transfer
   task automatic send_request(input logic [1:0] act, input logic [1:0] kind,
                               input logic [9:0] loc, input logic [3:0] bidx,
                               input logic [7:0] val);
      req_valid     <= 1'b1;
      req_action    <= act;
      req_addr_kind <= kind;
      req_location  <= loc;
      req_bit_index <= bidx;
      req_value_in  <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid for a few cycles
   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Wait until every predicted response has come back
   task automatic drain_responses();
      while (pending != 0) @(posedge clock);
   endtask

   // Address biased toward a few hot CVs so sets and reads meet
   function automatic logic [9:0] pick_location(input logic [1:0] kind);
      int sel;
      sel = $urandom_range(0, 19);
      if (kind == KIND_REG) begin
         if (sel == 0)
            return 10'd0;
         else if (sel == 1)
            return 10'($urandom_range(9, 1023));
         else
            return 10'($urandom_range(REG_FIRST, REG_LAST));
      end
      if (sel < 6)
         return 10'($urandom_range(0, 7));
      else if (sel < 8)
         return REG5_CV;
      else if (sel < 10)
         return 10'd255;
      else if (sel == 10)
         return 10'($urandom_range(256, 1023));
      else
         return 10'($urandom_range(0, 255));
   endfunction

   function automatic logic [3:0] pick_bit();
      return ($urandom_range(0, 15) == 0) ? 4'($urandom_range(8, 15))
                                          : 4'($urandom_range(0, 7));
   endfunction

   // Bit accesses mostly carry 0 or 1
   function automatic logic [7:0] pick_value(input logic [1:0] kind);
      if (kind == KIND_BIT && $urandom_range(0, 9) != 0)
         return 8'($urandom_range(0, 1));
      return 8'($urandom_range(0, 255));
   endfunction

   // Stimulus and verdict
   initial begin
      int         sent;
      int         pattern;
      logic [1:0] act;
      logic [1:0] kind;
      logic [9:0] loc;
      logic [3:0] bidx;
      logic [7:0] val;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: register map, page behavior, range limits, bit access
      send_request(ACT_GET,    KIND_REG,  10'd1,    4'd0,  8'h00);
      send_request(ACT_SET,    KIND_REG,  REG_PAGE, 4'd0,  8'hA5);
      send_request(ACT_GET,    KIND_REG,  REG_PAGE, 4'd0,  8'h00);
      send_request(ACT_GET,    KIND_REG,  10'd2,    4'd0,  8'h00);
      send_request(ACT_GET,    KIND_REG,  REG_PAGE, 4'd0,  8'h00);
      send_request(ACT_SET,    KIND_REG,  REG_CFG,  4'd0,  8'hFF);
      send_request(ACT_GET,    KIND_CV,   REG5_CV,  4'd0,  8'h00);
      send_request(ACT_VERIFY, KIND_PAGE, REG5_CV,  4'd0,  8'hFF);
      send_request(ACT_GET,    KIND_REG,  10'd0,    4'd0,  8'h00);
      send_request(ACT_GET,    KIND_REG,  10'd9,    4'd0,  8'h00);
      send_request(ACT_SET,    KIND_REG,  10'd1023, 4'd0,  8'h12);
      send_request(ACT_SET,    KIND_CV,   10'd255,  4'd0,  8'h80);
      send_request(ACT_GET,    KIND_CV,   10'd256,  4'd0,  8'h00);
      send_request(ACT_SET,    KIND_PAGE, 10'd1023, 4'd0,  8'h33);
      send_request(ACT_SET,    KIND_BIT,  10'd255,  4'd0,  8'h01);
      send_request(ACT_GET,    KIND_BIT,  10'd255,  4'd7,  8'h00);
      send_request(ACT_GET,    KIND_BIT,  10'd255,  4'd8,  8'h00);
      send_request(ACT_SET,    KIND_BIT,  10'd255,  4'd15, 8'h01);
      send_request(ACT_SET,    KIND_BIT,  10'd255,  4'd1,  8'h02);
      send_request(ACT_VERIFY, KIND_BIT,  10'd255,  4'd0,  8'hFE);
      send_request(ACT_VERIFY, KIND_CV,   10'd255,  4'd0,  8'h81);
      send_request(ACT_UNUSED, KIND_CV,   10'd0,    4'd0,  8'h00);
      send_request(ACT_SET,    KIND_REG,  REG_PAGE, 4'd0,  8'h07);
      send_request(ACT_VERIFY, KIND_REG,  10'd3,    4'd0,  8'hEE);
      send_request(ACT_GET,    KIND_REG,  REG_PAGE, 4'd0,  8'h00);

      // Hold off until the block has gone quiet
      idle_sender(1);
      drain_responses();

      // Random: mostly set-then-check sequences, some single ops and noise
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady <= (sent >= 300 && sent < 500);
         if (sent == 650) begin
            idle_sender(1);
            drain_responses();
         end
         if (!(sent >= 300 && sent < 500) && $urandom_range(0, 99) < 4)
            idle_sender($urandom_range(1, 3));
         kind    = 2'($urandom_range(0, 3));
         loc     = pick_location(kind);
         bidx    = pick_bit();
         val     = pick_value(kind);
         pattern = $urandom_range(0, 9);
         if (pattern < 4) begin
            // set then verify the same value
            send_request(ACT_SET, kind, loc, bidx, val);
            send_request(ACT_VERIFY, kind, loc, bidx, val);
            sent += 2;
         end else if (pattern < 6) begin
            // set then read back
            send_request(ACT_SET, kind, loc, bidx, val);
            send_request(ACT_GET, kind, loc, bidx, 8'h00);
            sent += 2;
         end else begin
            act = ($urandom_range(0, 29) == 0) ? ACT_UNUSED : 2'($urandom_range(0, 2));
            send_request(act, kind, loc, bidx, val);
            sent += 1;
         end
      end
      steady <= 1'b0;
      idle_sender(1);

      // Let the pipeline empty, then give the verdict
      drain_responses();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Overall time limit
   initial begin
      #500000;
      $display("simulation failed");
      $finish;
   end

endmodule

/* decoder_cv_store_core.f */
+incdir+design
design/cvs_pkg.sv
design/cvs_decode.sv
design/cvs_exec.sv
design/cvs_mem.sv
design/decoder_cv_store_core.sv
tb/cv_store_checker.sv
tb/tb_decoder_cv_store_core.sv
